// ===== design/dspg_pkg.sv =====
// Package for the dual servo pulse generator.
// Holds widths, reset values, codes and the stage payload structs.
// No dependencies.
package dspg_pkg;

    localparam int POS_W     = 15;
    localparam int CNT_W     = 16;
    localparam int DEG_W     = 8;
    localparam int PROD_W    = DEG_W + POS_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [POS_W-1:0] DEG_MAX = POS_W'(180);

    // Division by 180 as a multiply by a rounded-up reciprocal, exact for PROD_W-bit values.
    localparam int                  RECIP_W     = 24;
    localparam int                  RECIP_SHIFT = 31;
    localparam logic [RECIP_W-1:0]  RECIP_MULT  = RECIP_W'(11930465);
    localparam int                  SCALE_W     = PROD_W + RECIP_W;

    localparam logic [POS_W-1:0] RST_ZERO_DEG  = POS_W'(544);
    localparam logic [POS_W-1:0] RST_MAX_DEG   = POS_W'(2400);
    localparam logic [CNT_W-1:0] RST_PERIOD    = CNT_W'(40000);
    localparam logic [CNT_W-1:0] RST_THRESHOLD = CNT_W'(10000);

    typedef enum logic
    {
        OP_TICK,
        OP_WRITE
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_ZERO_DEG,
        REG_MAX_DEG,
        REG_PERIOD_TOP,
        REG_THRESHOLD
    } cfg_reg_t;

    typedef struct packed
    {
        logic [POS_W-1:0] zero_deg;
        logic [POS_W-1:0] max_deg;
        logic [CNT_W-1:0] period_top;
        logic [CNT_W-1:0] threshold;
    } dspg_cfg_t;

    typedef struct packed
    {
        logic              is_write;
        logic              chan_b;
        logic              is_deg;
        logic              neg;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  counter;
        logic              en_a;
        logic              en_b;
        logic [PROD_W-1:0] prod;
    } dspg_s1_t;

    typedef struct packed
    {
        logic             is_write;
        logic             chan_b;
        logic             is_deg;
        logic             neg;
        logic [POS_W-1:0] pos;
        logic [CNT_W-1:0] counter;
        logic             en_a;
        logic             en_b;
        logic [POS_W-1:0] quot;
    } dspg_s2_t;

endpackage

// ===== design/dspg_if.sv =====
// Valid/ready channel interfaces for the dual servo pulse generator.
// Depends on dspg_pkg for field widths.
interface dspg_item_if import dspg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             operation;
    logic [POS_W-1:0] position_value;
    logic             channel_b;
    logic             update_fast;

    modport source (output valid, output operation, output position_value,
                    output channel_b, output update_fast, input ready);
    modport sink   (input valid, input operation, input position_value,
                    input channel_b, input update_fast, output ready);
endinterface

interface dspg_result_if import dspg_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             pin_a;
    logic             pin_b;
    logic [POS_W-1:0] pulse_us;
    logic [CNT_W-1:0] timer_count;

    modport source (output valid, output pin_a, output pin_b, output pulse_us,
                    output timer_count, input ready);
    modport sink   (input valid, input pin_a, input pin_b, input pulse_us,
                    input timer_count, output ready);
endinterface

// ===== design/dual_servo_pwm_generator_core.sv =====
// Dual servo pulse generator, top level: register bank and a three-stage pipeline.
// Depends on dspg_pkg, dspg_if, dspg_regs, dspg_timer, dspg_scale, dspg_result.
//
// Every transaction on item gives exactly one transaction on result, in order.
// The block takes one item per clock while item.ready is high. A result is valid on result
// once its item has passed the three pipeline registers in order: the counter and enable
// update with the degree product, the multiply by the reciprocal of 180, and the width,
// compare update and pin evaluation. item.ready drops only while all three stages hold
// items and result is stalled. Write configuration registers only while no transaction
// is in flight.
module dual_servo_pwm_generator_core import dspg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    dspg_item_if.sink            item,
    dspg_result_if.source        result
);

    dspg_cfg_t cfg;
    logic      s1_valid;
    dspg_s1_t  s1;
    logic      s2_ready;
    logic      s2_valid;
    dspg_s2_t  s2;
    logic      s3_ready;

    dspg_regs u_regs
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    dspg_timer u_timer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item        (item),
        .down_ready  (s2_ready),
        .stage_valid (s1_valid),
        .stage       (s1)
    );

    dspg_scale u_scale
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (s1_valid),
        .up          (s1),
        .up_ready    (s2_ready),
        .down_ready  (s3_ready),
        .stage_valid (s2_valid),
        .stage       (s2)
    );

    dspg_result u_result
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .up_valid (s2_valid),
        .up       (s2),
        .up_ready (s3_ready),
        .result   (result)
    );

endmodule

// ===== design/dspg_regs.sv =====
// Configuration register bank of the dual servo pulse generator.
// Depends on dspg_pkg.
module dspg_regs import dspg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output dspg_cfg_t            cfg
);

    dspg_cfg_t cfg_reg;
    dspg_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ZERO_DEG:   cfg_next.zero_deg   = cfg_data[POS_W-1:0];
                REG_MAX_DEG:    cfg_next.max_deg    = cfg_data[POS_W-1:0];
                REG_PERIOD_TOP: cfg_next.period_top = cfg_data[CNT_W-1:0];
                REG_THRESHOLD:  cfg_next.threshold  = cfg_data[CNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.zero_deg   <= RST_ZERO_DEG;
            cfg_reg.max_deg    <= RST_MAX_DEG;
            cfg_reg.period_top <= RST_PERIOD;
            cfg_reg.threshold  <= RST_THRESHOLD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dspg_timer.sv =====
// First stage: takes transactions, advances the counter, enables and run flag,
// and forms the degree product. Depends on dspg_pkg and dspg_if.
module dspg_timer import dspg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dspg_cfg_t  cfg,
    dspg_item_if.sink  item,
    input  logic       down_ready,
    output logic       stage_valid,
    output dspg_s1_t   stage
);

    logic [CNT_W-1:0] counter_reg;
    logic [CNT_W-1:0] counter_next;
    logic             en_a_reg;
    logic             en_a_next;
    logic             en_b_reg;
    logic             en_b_next;
    logic             running_reg;
    logic             running_next;
    logic             valid_reg;
    logic             valid_next;
    dspg_s1_t         stage_reg;
    dspg_s1_t         stage_next;

    logic             accept;
    logic             neg;
    logic [POS_W-1:0] mag;

    assign item.ready = !valid_reg || down_ready;
    assign accept     = item.valid && item.ready;

    assign neg = cfg.max_deg < cfg.zero_deg;
    assign mag = neg ? (cfg.zero_deg - cfg.max_deg) : (cfg.max_deg - cfg.zero_deg);

    always_comb
    begin
        counter_next = counter_reg;
        en_a_next    = en_a_reg;
        en_b_next    = en_b_reg;
        running_next = running_reg;
        if (accept)
        begin
            if (item.operation == OP_TICK)
            begin
                if (running_reg)
                begin
                    counter_next = (counter_reg >= cfg.period_top) ? '0
                                                                   : counter_reg + CNT_W'(1);
                end
            end
            else
            begin
                running_next = 1'b1;
                if (item.channel_b)
                begin
                    en_b_next = 1'b1;
                end
                else
                begin
                    en_a_next = 1'b1;
                end
                if (item.update_fast && (counter_reg > cfg.threshold))
                begin
                    counter_next = (cfg.period_top == '0) ? '0
                                                          : cfg.period_top - CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        valid_next = item.ready ? item.valid : valid_reg;
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.is_write = (item.operation == OP_WRITE);
            stage_next.chan_b   = item.channel_b;
            stage_next.is_deg   = (item.position_value <= DEG_MAX);
            stage_next.neg      = neg;
            stage_next.pos      = item.position_value;
            stage_next.counter  = counter_next;
            stage_next.en_a     = en_a_next;
            stage_next.en_b     = en_b_next;
            stage_next.prod     = PROD_W'(item.position_value[DEG_W-1:0]) * PROD_W'(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            en_a_reg    <= 1'b0;
            en_b_reg    <= 1'b0;
            running_reg <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            counter_reg <= counter_next;
            en_a_reg    <= en_a_next;
            en_b_reg    <= en_b_next;
            running_reg <= running_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== design/dspg_scale.sv =====
// Second stage: divides the degree product by 180 with a reciprocal multiply.
// Depends on dspg_pkg.
module dspg_scale import dspg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      up_valid,
    input  dspg_s1_t  up,
    output logic      up_ready,
    input  logic      down_ready,
    output logic      stage_valid,
    output dspg_s2_t  stage
);

    logic             valid_reg;
    logic             valid_next;
    dspg_s2_t         stage_reg;
    dspg_s2_t         stage_next;
    logic [SCALE_W-1:0] scaled;

    assign up_ready = !valid_reg || down_ready;
    assign scaled   = SCALE_W'(up.prod) * SCALE_W'(RECIP_MULT);

    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        stage_next = stage_reg;
        if (up_valid && up_ready)
        begin
            stage_next.is_write = up.is_write;
            stage_next.chan_b   = up.chan_b;
            stage_next.is_deg   = up.is_deg;
            stage_next.neg      = up.neg;
            stage_next.pos      = up.pos;
            stage_next.counter  = up.counter;
            stage_next.en_a     = up.en_a;
            stage_next.en_b     = up.en_b;
            stage_next.quot     = scaled[RECIP_SHIFT +: POS_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;

endmodule

// ===== design/dspg_result.sv =====
// Last stage: forms the pulse width, updates the compare values, evaluates
// the pins and holds the result register. Depends on dspg_pkg and dspg_if.
module dspg_result import dspg_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  dspg_cfg_t    cfg,
    input  logic         up_valid,
    input  dspg_s2_t     up,
    output logic         up_ready,
    dspg_result_if.source result
);

    logic [CNT_W-1:0] cmp_a_reg;
    logic [CNT_W-1:0] cmp_a_next;
    logic [CNT_W-1:0] cmp_b_reg;
    logic [CNT_W-1:0] cmp_b_next;
    logic             valid_reg;
    logic             valid_next;
    logic             pin_a_reg;
    logic             pin_a_next;
    logic             pin_b_reg;
    logic             pin_b_next;
    logic [POS_W-1:0] pulse_reg;
    logic [POS_W-1:0] pulse_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             load;
    logic [POS_W-1:0] width;
    logic [CNT_W-1:0] cmp_new;

    assign up_ready = !valid_reg || result.ready;
    assign load     = up_valid && up_ready;

    always_comb
    begin
        if (!up.is_deg)
        begin
            width = up.pos;
        end
        else if (up.neg)
        begin
            width = cfg.zero_deg - up.quot;
        end
        else
        begin
            width = cfg.zero_deg + up.quot;
        end
    end

    assign cmp_new = {width, 1'b0};

    always_comb
    begin
        cmp_a_next = cmp_a_reg;
        cmp_b_next = cmp_b_reg;
        valid_next = up_ready ? up_valid : valid_reg;
        pin_a_next = pin_a_reg;
        pin_b_next = pin_b_reg;
        pulse_next = pulse_reg;
        count_next = count_reg;
        if (load)
        begin
            if (up.is_write)
            begin
                if (up.chan_b)
                begin
                    cmp_b_next = cmp_new;
                end
                else
                begin
                    cmp_a_next = cmp_new;
                end
            end
            pin_a_next = up.en_a && (up.counter < cmp_a_next);
            pin_b_next = up.en_b && (up.counter < cmp_b_next);
            pulse_next = up.is_write ? width : '0;
            count_next = up.counter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_a_reg <= '0;
            cmp_b_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cmp_a_reg <= cmp_a_next;
            cmp_b_reg <= cmp_b_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pin_a_reg <= pin_a_next;
        pin_b_reg <= pin_b_next;
        pulse_reg <= pulse_next;
        count_reg <= count_next;
    end

    assign result.valid       = valid_reg;
    assign result.pin_a       = pin_a_reg;
    assign result.pin_b       = pin_b_reg;
    assign result.pulse_us    = pulse_reg;
    assign result.timer_count = count_reg;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the dual servo pulse generator core.
// Predicts pin levels, pulse widths and counter values per transaction and checks results.
// Depends on dspg_pkg, dspg_if and the design under design/.
module tb_top import dspg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 190;
    localparam int PIPE_LATENCY   = 3;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed
    {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic             chan_b;
        logic             fast;
    } servo_item_t;

    typedef struct packed
    {
        logic             pin_a;
        logic             pin_b;
        logic [POS_W-1:0] pulse_us;
        logic [CNT_W-1:0] timer_count;
    } pulse_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_write_en;
    cfg_reg_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    dspg_item_if   item_bus();
    dspg_result_if result_bus();

    dual_servo_pwm_generator_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item_bus),
        .result       (result_bus)
    );

    logic [POS_W-1:0] cfg_zero_us;
    logic [POS_W-1:0] cfg_max_us;
    logic [CNT_W-1:0] cfg_top;
    logic [CNT_W-1:0] cfg_threshold;

    logic [CNT_W-1:0] servo_count;
    logic [CNT_W-1:0] servo_cmp_a;
    logic [CNT_W-1:0] servo_cmp_b;
    logic             servo_en_a;
    logic             servo_en_b;
    logic             servo_running;

    servo_item_t   pending_items[$];
    pulse_result_t expected_pulses[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_req = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    int n_items = 0;
    int n_writes = 0;
    int n_wraps = 0;
    int n_fast = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_reported = 0;

    always #1 clk = ~clk;

    function automatic logic [POS_W-1:0] width_from_degrees(logic [POS_W-1:0] deg);
        int lo;
        int hi;
        int w;
        lo = int'(cfg_zero_us);
        hi = int'(cfg_max_us);
        w = lo + (int'(deg) * (hi - lo)) / int'(DEG_MAX);
        return w[POS_W-1:0];
    endfunction

    function automatic pulse_result_t advance_servo(servo_item_t it);
        pulse_result_t    r;
        logic [POS_W-1:0] width;
        width = '0;
        if (it.op == OP_TICK)
        begin
            if (servo_running)
            begin
                if (servo_count >= cfg_top)
                begin
                    servo_count = '0;
                    n_wraps++;
                end
                else
                    servo_count = servo_count + 1'b1;
            end
        end
        else
        begin
            width = (it.pos <= DEG_MAX) ? width_from_degrees(it.pos) : it.pos;
            servo_running = 1'b1;
            if (it.chan_b)
                servo_en_b = 1'b1;
            else
                servo_en_a = 1'b1;
            if (it.fast && servo_count > cfg_threshold)
            begin
                servo_count = (cfg_top == '0) ? '0 : cfg_top - 1'b1;
                n_fast++;
            end
            if (it.chan_b)
                servo_cmp_b = {width, 1'b0};
            else
                servo_cmp_a = {width, 1'b0};
        end
        r.pin_a       = servo_en_a && (servo_count < servo_cmp_a);
        r.pin_b       = servo_en_b && (servo_count < servo_cmp_b);
        r.pulse_us    = width;
        r.timer_count = servo_count;
        return r;
    endfunction

    function automatic servo_item_t random_item();
        servo_item_t it;
        it.op     = ($urandom_range(99) < 30) ? OP_WRITE : OP_TICK;
        it.pos    = ($urandom_range(99) < 40) ? POS_W'($urandom_range(180)) : POS_W'($urandom);
        it.chan_b = 1'($urandom_range(1));
        it.fast   = 1'($urandom_range(1));
        return it;
    endfunction

    always @(posedge clk)
    begin
        servo_item_t next_item;
        if (rst_n && (!item_bus.valid || item_bus.ready))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = pending_items.pop_front();
                item_bus.valid          <= 1'b1;
                item_bus.operation      <= next_item.op;
                item_bus.position_value <= next_item.pos;
                item_bus.channel_b      <= next_item.chan_b;
                item_bus.update_fast    <= next_item.fast;
            end
            else
                item_bus.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen        <= hold_req;
            hold_left        <= HOLD_CYCLES;
            result_bus.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left        <= hold_left - 1;
            result_bus.ready <= 1'b0;
        end
        else
            result_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        servo_item_t   seen;
        pulse_result_t got;
        pulse_result_t want;
        if (rst_n)
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                got = '{result_bus.pin_a, result_bus.pin_b, result_bus.pulse_us,
                        result_bus.timer_count};
                if (expected_pulses.size() == 0)
                begin
                    n_errors++;
                    if (n_reported < MAX_REPORTS)
                    begin
                        n_reported++;
                        $display("%0t: unexpected result pin_a=%0b pin_b=%0b pulse_us=%0d count=%0d",
                                 $time, got.pin_a, got.pin_b, got.pulse_us, got.timer_count);
                    end
                end
                else
                begin
                    want = expected_pulses.pop_front();
                    n_checked++;
                    if (got !== want)
                    begin
                        n_errors++;
                        if (n_reported < MAX_REPORTS)
                        begin
                            n_reported++;
                            $display("%0t: mismatch expected pin_a=%0b pin_b=%0b pulse_us=%0d count=%0d",
                                     $time, want.pin_a, want.pin_b, want.pulse_us,
                                     want.timer_count);
                            $display("%0t:          actual   pin_a=%0b pin_b=%0b pulse_us=%0d count=%0d",
                                     $time, got.pin_a, got.pin_b, got.pulse_us, got.timer_count);
                        end
                    end
                end
            end
            if (item_bus.valid && item_bus.ready)
            begin
                seen.op     = op_t'(item_bus.operation);
                seen.pos    = item_bus.position_value;
                seen.chan_b = item_bus.channel_b;
                seen.fast   = item_bus.update_fast;
                n_items++;
                if (seen.op == OP_WRITE)
                    n_writes++;
                expected_pulses.push_back(advance_servo(seen));
            end
            if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_ZERO_DEG:   cfg_zero_us   = value[POS_W-1:0];
            REG_MAX_DEG:    cfg_max_us    = value[POS_W-1:0];
            REG_PERIOD_TOP: cfg_top       = value[CNT_W-1:0];
            REG_THRESHOLD:  cfg_threshold = value[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(int zero_us, int max_us, int top, int threshold);
        write_reg(REG_ZERO_DEG, CFG_W'(zero_us));
        write_reg(REG_MAX_DEG, CFG_W'(max_us));
        write_reg(REG_PERIOD_TOP, CFG_W'(top));
        write_reg(REG_THRESHOLD, CFG_W'(threshold));
    endtask

    task automatic set_short_period();
        int top;
        top = $urandom_range(2, 400);
        set_timing($urandom_range(150), $urandom_range(150), top, $urandom_range(top));
    endtask

    task automatic push_item(op_t op, int pos, logic chan_b, logic fast);
        servo_item_t it;
        it.op     = op;
        it.pos    = POS_W'(pos);
        it.chan_b = chan_b;
        it.fast   = fast;
        pending_items.push_back(it);
    endtask

    task automatic load_items(int count);
        @(negedge clk);
        repeat (count)
            pending_items.push_back(random_item());
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || item_bus.valid || expected_pulses.size() != 0);
    endtask

    task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        load_items(PHASE_ITEMS);
        wait_drained();
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        cfg_write_en            = 1'b0;
        cfg_index               = REG_ZERO_DEG;
        cfg_data                = '0;
        item_bus.valid          = 1'b0;
        item_bus.operation      = OP_TICK;
        item_bus.position_value = '0;
        item_bus.channel_b      = 1'b0;
        item_bus.update_fast    = 1'b0;
        result_bus.ready        = 1'b0;
        cfg_zero_us             = RST_ZERO_DEG;
        cfg_max_us              = RST_MAX_DEG;
        cfg_top                 = RST_PERIOD;
        cfg_threshold           = RST_THRESHOLD;
        servo_count             = '0;
        servo_cmp_a             = '0;
        servo_cmp_b             = '0;
        servo_en_a              = 1'b0;
        servo_en_b              = 1'b0;
        servo_running           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // hold the counter while stopped, then map both degree extremes and microsecond values
        @(negedge clk);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_WRITE, 0, 1'b0, 1'b0);
        push_item(OP_WRITE, 180, 1'b1, 1'b1);
        push_item(OP_TICK, 32767, 1'b1, 1'b1);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_WRITE, 90, 1'b0, 1'b0);
        push_item(OP_WRITE, 181, 1'b1, 1'b0);
        push_item(OP_WRITE, 32767, 1'b0, 1'b1);
        push_item(OP_WRITE, 179, 1'b1, 1'b0);
        push_item(OP_WRITE, 16384, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        wait_drained();

        // wrap at top, fast writes with the counter at or below the threshold, then top lowered
        set_timing(0, 2, 4, 1);
        @(negedge clk);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_WRITE, 100, 1'b1, 1'b1);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        wait_drained();
        write_reg(REG_PERIOD_TOP, CFG_W'(2));
        @(negedge clk);
        push_item(OP_TICK, 0, 1'b0, 1'b0);
        push_item(OP_WRITE, 1, 1'b0, 1'b1);
        wait_drained();

        set_timing(0, 32767, 65535, 0);
        run_phase(0, 0);

        set_timing(32767, 0, 1, 65535);
        run_phase(84, 0);

        set_short_period();
        run_phase(0, 84);

        set_short_period();
        run_phase(6, 6);

        // stall the result side while items keep coming, then pause until all results are back
        set_short_period();
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_items(PHASE_ITEMS / 2);
        hold_req++;
        wait_drained();
        load_items(PHASE_ITEMS / 2);
        wait_drained();

        set_timing($urandom, $urandom, $urandom_range(1, 65535), $urandom_range(65535));
        run_phase(6, 6);

        repeat (PIPE_LATENCY + 2) @(posedge clk);
        n_errors += expected_pulses.size();
        $display("covered %0d transactions: %0d position writes, %0d counter wraps, %0d fast restarts",
                 n_items, n_writes, n_wraps, n_fast);
        $display("checked %0d results across idle, stall and back-pressure phases, %0d failures",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== dual_servo_pwm_generator_core.f =====
design/dspg_pkg.sv
design/dspg_if.sv
design/dspg_regs.sv
design/dspg_timer.sv
design/dspg_scale.sv
design/dspg_result.sv
design/dual_servo_pwm_generator_core.sv
tb/tb_top.sv
